// ===== design/tcc_pkg.sv =====
// Shared types, widths and codes for the touch coordinate calibrator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package tcc_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int SIZE_W      = 14;
    localparam int RAW_W       = 16;
    localparam int FLAG_W      = 2;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_DATA_W   = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int OUT_VAL_W   = 31;
    localparam int OUT_DATA_W  = ((OUT_VAL_W + 7) / 8) * 8;
    localparam int DIFF_W      = VALUE_WIDTH + 2;
    localparam int MAG_W       = VALUE_WIDTH + 1;
    localparam int PROD_W      = MAG_W + SIZE_W;
    localparam int SGN_W       = PROD_W + 2;
    localparam int CLAMP_W     = SIZE_W + 1;
    localparam int CNT_W       = $clog2(PROD_W + 1);

    typedef enum logic [1:0] {
        CMD_X     = 2'd0,
        CMD_Y     = 2'd1,
        CMD_TOUCH = 2'd2,
        CMD_OTHER = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_X      = 2'd0,
        KIND_Y      = 2'd1,
        KIND_BUTTON = 2'd2,
        KIND_OTHER  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rot;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH    = 3'd0,
        REG_HEIGHT   = 3'd1,
        REG_X_LOW    = 3'd2,
        REG_X_HIGH   = 3'd3,
        REG_Y_LOW    = 3'd4,
        REG_Y_HIGH   = 3'd5,
        REG_MIRROR   = 3'd6,
        REG_ROTATION = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_POST,
        ST_PUT1,
        ST_PUT2
    } t_state;

    typedef struct packed {
        logic [SIZE_W-1:0] display_width;
        logic [SIZE_W-1:0] display_height;
        logic [RAW_W-1:0]  raw_x_low;
        logic [RAW_W-1:0]  raw_x_high;
        logic [RAW_W-1:0]  raw_y_low;
        logic [RAW_W-1:0]  raw_y_high;
        logic [FLAG_W-1:0] mirror_flags;
        t_rot              rotation;
    } t_cfg;

    localparam logic [SIZE_W-1:0] RST_WIDTH  = SIZE_W'(1920);
    localparam logic [SIZE_W-1:0] RST_HEIGHT = SIZE_W'(1080);
    localparam logic [RAW_W-1:0]  RST_LOW    = RAW_W'(0);
    localparam logic [RAW_W-1:0]  RST_HIGH   = RAW_W'(4095);

endpackage

// ===== design/tcc_cfg_regs.sv =====
// Configuration register file of the touch coordinate calibrator.
// Depends on tcc_pkg.
`timescale 1ns / 1ps

module tcc_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tcc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tcc_pkg::CFG_W-1:0]       i_cfg_data,
    output tcc_pkg::t_cfg                   o_cfg
);
    import tcc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.display_width  <= RST_WIDTH;
            r_cfg.display_height <= RST_HEIGHT;
            r_cfg.raw_x_low      <= RST_LOW;
            r_cfg.raw_x_high     <= RST_HIGH;
            r_cfg.raw_y_low      <= RST_LOW;
            r_cfg.raw_y_high     <= RST_HIGH;
            r_cfg.mirror_flags   <= '0;
            r_cfg.rotation       <= ROT_0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_WIDTH:    r_cfg.display_width  <= i_cfg_data[SIZE_W-1:0];
                REG_HEIGHT:   r_cfg.display_height <= i_cfg_data[SIZE_W-1:0];
                REG_X_LOW:    r_cfg.raw_x_low      <= i_cfg_data[RAW_W-1:0];
                REG_X_HIGH:   r_cfg.raw_x_high     <= i_cfg_data[RAW_W-1:0];
                REG_Y_LOW:    r_cfg.raw_y_low      <= i_cfg_data[RAW_W-1:0];
                REG_Y_HIGH:   r_cfg.raw_y_high     <= i_cfg_data[RAW_W-1:0];
                REG_MIRROR:   r_cfg.mirror_flags   <= i_cfg_data[FLAG_W-1:0];
                REG_ROTATION: r_cfg.rotation       <= t_rot'(i_cfg_data[1:0]);
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/tcc_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Depends on tcc_pkg.
`timescale 1ns / 1ps

module tcc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tcc_pkg::PROD_W-1:0]   i_dividend,
    input  logic [tcc_pkg::RAW_W-1:0]    i_divisor,
    output logic                         o_done,
    output logic [tcc_pkg::PROD_W-1:0]   o_quotient
);
    import tcc_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [RAW_W-1:0]  r_rem, n_rem;
    logic [PROD_W-1:0] r_quo, n_quo;
    logic [RAW_W-1:0]  r_div, n_div;
    logic [RAW_W+1:0]  trial;
    logic              fits;

    always_comb begin
        trial  = {1'b0, r_rem, r_quo[PROD_W-1]} - {2'b00, r_div};
        fits   = !trial[RAW_W+1];
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(PROD_W);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem = fits ? trial[RAW_W-1:0] : {r_rem[RAW_W-2:0], r_quo[PROD_W-1]};
            n_quo = {r_quo[PROD_W-2:0], fits};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== design/touch_coordinate_calibrator.sv =====
// Top level of the touch coordinate calibrator: sequencer, event handling, output word.
// Depends on tcc_pkg, tcc_cfg_regs and tcc_div.
`timescale 1ns / 1ps
//
// Events enter on the s_axis channel: tuser carries the command, tdata the
// signed event value. Calibrated words leave on the m_axis channel: tuser
// carries the kind, tdata the value, tlast marks the final word of an event.
// Write registers via i_cfg_we/i_cfg_index/i_cfg_data only while idle (unenforced).
//
// One event is taken at a time; tready is high only while the sequencer idles.
// X or Y events: a multiply state, a serial divide of one quotient bit per cycle,
// one state of mirror and clamp, then the word is loaded once the output
// register frees. A touch release or other event goes to the load state on
// accept; a touch press arms the pending press and yields no word.
// A coordinate that completes a pending press is followed by a left-button
// word, loaded as soon as the output register frees.
// A stalled receiver holds the output word; the sequencer waits for space
// before loading the next word, so nothing is dropped.
// Reset clears the sequencer, the pending press and the output valid, and
// loads the register defaults.
//

module touch_coordinate_calibrator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [31:0] event_value
    input  logic [tcc_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // [1:0] command
    input  logic [1:0]                      i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [30:0] result_value, [31] zero
    output logic [tcc_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // [1:0] result_kind
    output logic [1:0]                      o_m_axis_tuser,
    output logic                            o_m_axis_tlast,
    input  logic                            i_cfg_we,
    input  logic [tcc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tcc_pkg::CFG_W-1:0]       i_cfg_data
);
    import tcc_pkg::*;

    t_cfg cfg;

    t_state                   r_state, n_state;
    t_cmd                     r_cmd, n_cmd;
    logic [VALUE_WIDTH-1:0]   r_value, n_value;
    logic [1:0]               r_pending, n_pending;
    logic                     r_press, n_press;
    logic                     r_neg, n_neg;
    logic                     r_ok, n_ok;
    logic signed [CLAMP_W-1:0] r_coord, n_coord;
    logic                     r_m_valid, n_m_valid;
    t_kind                    r_m_kind, n_m_kind;
    logic [OUT_VAL_W-1:0]     r_m_value, n_m_value;
    logic                     r_m_last, n_m_last;

    logic                     is_x;
    logic [SIZE_W-1:0]        size;
    logic [RAW_W-1:0]         lo;
    logic [RAW_W-1:0]         hi;
    logic                     mirror;
    logic signed [DIFF_W-1:0] sval;
    logic signed [DIFF_W-1:0] lo_ext;
    logic signed [DIFF_W-1:0] diff;
    logic [MAG_W-1:0]         mag;
    logic [PROD_W-1:0]        mul_out;
    logic                     div_start;
    logic                     div_done;
    logic [PROD_W-1:0]        div_quot;
    logic signed [SGN_W-1:0]  quot_s;
    logic signed [SGN_W-1:0]  q;
    logic signed [SGN_W-1:0]  size_s;
    logic signed [SGN_W-1:0]  mir;
    logic signed [CLAMP_W-1:0] size_c;
    logic signed [CLAMP_W-1:0] flipped;
    logic                     flip;
    t_kind                    coord_kind;
    logic                     out_free;
    logic                     in_fire;
    logic [1:0]               axis_bit;
    logic [1:0]               left;

    tcc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tcc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mul_out),
        .i_divisor  (hi - lo),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    always_comb begin
        is_x   = (r_cmd == CMD_X);
        size   = is_x ? cfg.display_width : cfg.display_height;
        lo     = is_x ? cfg.raw_x_low : cfg.raw_y_low;
        hi     = is_x ? cfg.raw_x_high : cfg.raw_y_high;
        mirror = is_x ? cfg.mirror_flags[0] : cfg.mirror_flags[1];

        sval    = DIFF_W'(signed'(r_value));
        lo_ext  = {{(DIFF_W-RAW_W){1'b0}}, lo};
        diff    = sval - lo_ext;
        mag     = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
        mul_out = mag * size;

        quot_s = {2'b00, div_quot};
        q      = r_neg ? -quot_s : quot_s;
        if (!r_ok) begin
            q = '0;
        end
        size_s = {{(SGN_W-SIZE_W){1'b0}}, size};
        mir    = mirror ? size_s - q : q;

        size_c = {1'b0, size};
        case (cfg.rotation)
            ROT_90: begin
                coord_kind = is_x ? KIND_Y : KIND_X;
                flip       = is_x;
            end
            ROT_180: begin
                coord_kind = is_x ? KIND_X : KIND_Y;
                flip       = 1'b1;
            end
            ROT_270: begin
                coord_kind = is_x ? KIND_Y : KIND_X;
                flip       = !is_x;
            end
            default: begin
                coord_kind = is_x ? KIND_X : KIND_Y;
                flip       = 1'b0;
            end
        endcase
        flipped = flip ? size_c - CLAMP_W'(1) - r_coord : r_coord;
    end

    assign out_free        = !r_m_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_value   = r_value;
        n_pending = r_pending;
        n_press   = r_press;
        n_neg     = r_neg;
        n_ok      = r_ok;
        n_coord   = r_coord;
        n_m_valid = r_m_valid && !i_m_axis_tready;
        n_m_kind  = r_m_kind;
        n_m_value = r_m_value;
        n_m_last  = r_m_last;
        div_start = 1'b0;
        axis_bit  = (t_cmd'(i_s_axis_tuser) == CMD_X) ? 2'b01 : 2'b10;
        left      = r_pending & ~axis_bit;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_cmd   = t_cmd'(i_s_axis_tuser);
                    n_value = i_s_axis_tdata[VALUE_WIDTH-1:0];
                    n_press = 1'b0;
                    case (t_cmd'(i_s_axis_tuser))
                        CMD_X, CMD_Y: begin
                            n_state = ST_MUL;
                            if ((r_pending & axis_bit) != 2'b00) begin
                                n_pending = left;
                                n_press   = (left == 2'b00);
                            end
                        end
                        CMD_TOUCH: begin
                            if (|i_s_axis_tdata[VALUE_WIDTH-1:0]) begin
                                n_pending = 2'b11;
                            end else begin
                                n_state = ST_PUT1;
                            end
                        end
                        default: n_state = ST_PUT1;
                    endcase
                end
            end
            ST_MUL: begin
                div_start = 1'b1;
                n_neg     = diff[DIFF_W-1];
                n_ok      = (hi > lo);
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_POST;
                end
            end
            ST_POST: begin
                if (mir[SGN_W-1]) begin
                    n_coord = '0;
                end else if (mir >= size_s) begin
                    n_coord = size_c - CLAMP_W'(1);
                end else begin
                    n_coord = mir[CLAMP_W-1:0];
                end
                n_state = ST_PUT1;
            end
            ST_PUT1: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_last  = !r_press;
                    case (r_cmd)
                        CMD_X, CMD_Y: begin
                            n_m_kind  = coord_kind;
                            n_m_value = flipped[CLAMP_W-1] ? '0
                                                           : OUT_VAL_W'(flipped);
                        end
                        CMD_TOUCH: begin
                            n_m_kind  = KIND_BUTTON;
                            n_m_value = '0;
                        end
                        default: begin
                            n_m_kind  = KIND_OTHER;
                            n_m_value = r_value[VALUE_WIDTH-1] ? '0
                                                               : OUT_VAL_W'(r_value);
                        end
                    endcase
                    n_state = r_press ? ST_PUT2 : ST_IDLE;
                end
            end
            ST_PUT2: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_kind  = KIND_BUTTON;
                    n_m_value = OUT_VAL_W'(1);
                    n_m_last  = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pending <= 2'b00;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_value   <= n_value;
        r_press   <= n_press;
        r_neg     <= n_neg;
        r_ok      <= n_ok;
        r_coord   <= n_coord;
        r_m_kind  <= n_m_kind;
        r_m_value <= n_m_value;
        r_m_last  <= n_m_last;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_m_value);
    assign o_m_axis_tuser  = r_m_kind;
    assign o_m_axis_tlast  = r_m_last;

endmodule

// ===== verif/touch_coordinate_calibrator_test.sv =====
// Self-checking testbench for touch_coordinate_calibrator: drives events on the input stream,
// predicts each calibrated word in a scoreboard class and checks the output stream against it.
// Depends on tcc_pkg and the touch_coordinate_calibrator RTL.
`timescale 1ns / 1ps

module touch_coordinate_calibrator_test;
    import tcc_pkg::*;

    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 152;
    localparam int DRAIN_CYCLES    = 64;
    // one event: the serial divide, two words each behind a receiver stall, an input gap;
    // a register phase change adds the drain pause and eight writes
    localparam int STALL_LIMIT     = 2000;
    localparam logic [1:0] WAIT_BOTH = 2'b11;
    localparam logic [1:0] WAIT_X    = 2'b01;
    localparam logic [1:0] WAIT_Y    = 2'b10;

    typedef struct {
        t_kind       kind;
        logic [30:0] value;
        logic        last;
    } cal_word_t;

    class calib_scoreboard;
        logic [SIZE_W-1:0] width_px;
        logic [SIZE_W-1:0] height_px;
        logic [RAW_W-1:0]  x_low;
        logic [RAW_W-1:0]  x_high;
        logic [RAW_W-1:0]  y_low;
        logic [RAW_W-1:0]  y_high;
        logic [1:0]        mirror;
        t_rot              rot;
        logic [1:0]        touch_wait;
        cal_word_t         expected_words[$];
        int                errors;
        int                words_checked;
        int                events_seen;
        int                presses_done;

        function void reset_model();
            width_px   = RST_WIDTH;
            height_px  = RST_HEIGHT;
            x_low      = RST_LOW;
            x_high     = RST_HIGH;
            y_low      = RST_LOW;
            y_high     = RST_HIGH;
            mirror     = 2'b00;
            rot        = ROT_0;
            touch_wait = 2'b00;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_WIDTH:    width_px  = data[SIZE_W-1:0];
                REG_HEIGHT:   height_px = data[SIZE_W-1:0];
                REG_X_LOW:    x_low     = data[RAW_W-1:0];
                REG_X_HIGH:   x_high    = data[RAW_W-1:0];
                REG_Y_LOW:    y_low     = data[RAW_W-1:0];
                REG_Y_HIGH:   y_high    = data[RAW_W-1:0];
                REG_MIRROR:   mirror    = data[1:0];
                REG_ROTATION: rot       = t_rot'(data[1:0]);
                default: ;
            endcase
        endfunction

        function void push_word(t_kind kind, longint v, logic lst);
            cal_word_t w;
            if (v < 0)
                v = 0;
            w.kind  = kind;
            w.value = 31'(v);
            w.last  = lst;
            expected_words.push_back(w);
        endfunction

        function void note_event(t_cmd cmd, logic [31:0] data);
            longint raw;
            longint size;
            longint lo;
            longint hi;
            longint v;
            bit     is_x;
            bit     mir;
            bit     flip;
            bit     press;
            t_kind  kind;
            logic [1:0] axis_bit;
            raw = longint'($signed(data));
            events_seen++;
            case (cmd)
                CMD_X, CMD_Y: begin
                    is_x = (cmd == CMD_X);
                    size = is_x ? longint'(width_px) : longint'(height_px);
                    lo   = is_x ? longint'(x_low) : longint'(y_low);
                    hi   = is_x ? longint'(x_high) : longint'(y_high);
                    mir  = is_x ? mirror[0] : mirror[1];
                    v = 0;
                    if (hi > lo)
                        v = (size * (raw - lo)) / (hi - lo);
                    if (mir)
                        v = size - v;
                    if (v < 0)
                        v = 0;
                    if (v >= size)
                        v = size - 1;
                    kind = is_x ? KIND_X : KIND_Y;
                    flip = 1'b0;
                    case (rot)
                        ROT_90: begin
                            kind = is_x ? KIND_Y : KIND_X;
                            flip = is_x;
                        end
                        ROT_180: flip = 1'b1;
                        ROT_270: begin
                            kind = is_x ? KIND_Y : KIND_X;
                            flip = !is_x;
                        end
                        default: ;
                    endcase
                    if (flip)
                        v = size - v - 1;
                    axis_bit = is_x ? WAIT_X : WAIT_Y;
                    press = 1'b0;
                    if ((touch_wait & axis_bit) != 2'b00) begin
                        touch_wait = touch_wait & ~axis_bit;
                        press = (touch_wait == 2'b00);
                    end
                    push_word(kind, v, !press);
                    if (press) begin
                        push_word(KIND_BUTTON, 1, 1'b1);
                        presses_done++;
                    end
                end
                CMD_TOUCH: begin
                    if (raw != 0)
                        touch_wait = WAIT_BOTH;
                    else
                        push_word(KIND_BUTTON, 0, 1'b1);
                end
                default: push_word(KIND_OTHER, raw, 1'b1);
            endcase
        endfunction

        function void check_word(logic [1:0] kind, logic [OUT_DATA_W-1:0] data, logic lst);
            cal_word_t w;
            logic [OUT_DATA_W-1:0] want;
            words_checked++;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected word: kind %0d value %0d last %0d", kind, data, lst);
                return;
            end
            w = expected_words.pop_front();
            want = OUT_DATA_W'(w.value);
            if (kind !== w.kind || data !== want || lst !== w.last) begin
                errors++;
                if (errors <= 10)
                    $display("Mismatch on word %0d: expected kind %0d value %0d last %0d, got kind %0d value %0d last %0d",
                             words_checked, w.kind, want, w.last, kind, data, lst);
            end
        endfunction

        function int pending_words();
            return expected_words.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_s_axis_tvalid;
    logic                    o_s_axis_tready;
    logic [IN_DATA_W-1:0]    i_s_axis_tdata;
    logic [1:0]              i_s_axis_tuser;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready;
    logic [OUT_DATA_W-1:0]   o_m_axis_tdata;
    logic [1:0]              o_m_axis_tuser;
    logic                    o_m_axis_tlast;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_W-1:0]        i_cfg_data;

    calib_scoreboard sb = new();
    bit idle_on;
    int rx_hold;
    int quiet_cycles;

    touch_coordinate_calibrator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // hold the receiver off in random bursts
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            i_m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_m_axis_tready <= 1'b0;
            rx_hold <= $urandom_range(0, 6);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_word(o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_event(t_cmd cmd, logic [31:0] value);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        i_s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        sb.note_event(cmd, value);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_words() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        sb.write_reg(idx, data);
    endtask

    task automatic apply_setting(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                                 logic [CFG_W-1:0] xl, logic [CFG_W-1:0] xh,
                                 logic [CFG_W-1:0] yl, logic [CFG_W-1:0] yh,
                                 logic [1:0] mir, t_rot r);
        set_reg(REG_WIDTH, w);
        set_reg(REG_HEIGHT, h);
        set_reg(REG_X_LOW, xl);
        set_reg(REG_X_HIGH, xh);
        set_reg(REG_Y_LOW, yl);
        set_reg(REG_Y_HIGH, yh);
        set_reg(REG_MIRROR, CFG_W'(mir));
        set_reg(REG_ROTATION, CFG_W'(r));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_raw(t_cmd axis);
        int lo;
        int hi;
        int t;
        lo = (axis == CMD_X) ? int'(sb.x_low) : int'(sb.y_low);
        hi = (axis == CMD_X) ? int'(sb.x_high) : int'(sb.y_high);
        if (lo > hi) begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'(lo);
                    1: return 32'(hi);
                    2: return 32'(lo - 1);
                    default: return 32'(hi + 1);
                endcase
            end
            default: return 32'(lo - 64 + int'($urandom_range(0, hi - lo + 128)));
        endcase
    endfunction

    function automatic logic [31:0] nonzero_word();
        logic [31:0] v;
        do
            v = $urandom;
        while (v == 32'd0);
        return v;
    endfunction

    task automatic run_directed();
        send_event(CMD_X, 32'd0);
        send_event(CMD_X, 32'd4095);
        send_event(CMD_X, 32'd2048);
        send_event(CMD_Y, 32'd0);
        send_event(CMD_Y, 32'd4095);
        send_event(CMD_X, 32'hFFFF_FFFF);
        send_event(CMD_X, 32'h7FFF_FFFF);
        send_event(CMD_Y, 32'h8000_0000);
        send_event(CMD_TOUCH, 32'd1);
        send_event(CMD_X, 32'd100);
        send_event(CMD_Y, 32'd200);
        send_event(CMD_TOUCH, 32'd0);
        send_event(CMD_TOUCH, 32'h8000_0000);
        send_event(CMD_Y, 32'd3000);
        send_event(CMD_Y, 32'd3001);
        send_event(CMD_X, 32'd1000);
        send_event(CMD_TOUCH, 32'd0);
        send_event(CMD_OTHER, 32'd5);
        send_event(CMD_OTHER, 32'hFFFF_FFFB);
        send_event(CMD_OTHER, 32'h7FFF_FFFF);
        send_event(CMD_OTHER, 32'h8000_0000);
        send_event(CMD_OTHER, 32'd0);
    endtask

    task automatic run_random(int n);
        int   start;
        t_cmd a;
        t_cmd b;
        start = sb.events_seen;
        while (sb.events_seen - start < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    a = ($urandom_range(0, 1) == 0) ? CMD_X : CMD_Y;
                    b = (a == CMD_X) ? CMD_Y : CMD_X;
                    send_event(CMD_TOUCH, nonzero_word());
                    send_event(a, pick_raw(a));
                    if ($urandom_range(0, 4) == 0)
                        send_event(a, pick_raw(a));
                    send_event(b, pick_raw(b));
                    if ($urandom_range(0, 3) != 0)
                        send_event(CMD_TOUCH, 32'd0);
                end
                6, 7: begin
                    a = ($urandom_range(0, 1) == 0) ? CMD_X : CMD_Y;
                    send_event(a, pick_raw(a));
                end
                8: send_event(CMD_OTHER, $urandom);
                default: begin
                    a = t_cmd'($urandom_range(0, 3));
                    if (a == CMD_TOUCH && $urandom_range(0, 1) == 0)
                        send_event(a, 32'd0);
                    else
                        send_event(a, $urandom);
                end
            endcase
        end
    endtask

    task automatic random_setting();
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        logic [CFG_W-1:0] xl;
        logic [CFG_W-1:0] xh;
        logic [CFG_W-1:0] yl;
        logic [CFG_W-1:0] yh;
        logic [CFG_W-1:0] t;
        w  = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(1, 8192));
        h  = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom) : CFG_W'($urandom_range(1, 8192));
        xl = CFG_W'($urandom);
        xh = CFG_W'($urandom);
        yl = CFG_W'($urandom);
        yh = CFG_W'($urandom);
        if ($urandom_range(0, 5) != 0 && xl > xh) begin
            t  = xl;
            xl = xh;
            xh = t;
        end
        if ($urandom_range(0, 5) != 0 && yl > yh) begin
            t  = yl;
            yl = yh;
            yh = t;
        end
        apply_setting(w, h, xl, xh, yl, yh, 2'($urandom), t_rot'($urandom_range(0, 3)));
    endtask

    initial begin
        bit failed;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = CMD_X;
        i_m_axis_tready = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = REG_WIDTH;
        i_cfg_data      = '0;
        idle_on         = 1'b1;
        rx_hold         = 0;
        quiet_cycles    = 0;
        sb.reset_model();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                drain();
                case (phase)
                    1: apply_setting(16'd8192, 16'd8192, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF,
                                     2'b11, ROT_90);
                    2: apply_setting(16'd1, 16'd1, 16'd100, 16'd4000, 16'd200, 16'd3000,
                                     2'b01, ROT_180);
                    3: apply_setting(16'd0, 16'd0, 16'd0, 16'd4095, 16'd0, 16'd4095,
                                     2'b10, ROT_270);
                    4: apply_setting(16'd800, 16'd480, 16'd4000, 16'd100, 16'd3000, 16'd3000,
                                     2'b00, ROT_90);
                    5: apply_setting(16'hFFFF, 16'h3FFF, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF,
                                     2'b11, ROT_180);
                    6: apply_setting(16'd320, 16'd240, 16'd200, 16'd3900, 16'd150, 16'd3950,
                                     2'b01, ROT_270);
                    default: random_setting();
                endcase
            end
            if (phase == PHASES - 1)
                idle_on = 1'b0;
            run_random(ITEMS_PER_PHASE);
        end
        drain();

        failed = (sb.errors != 0) || (sb.pending_words() != 0);
        $display("Sent %0d events under %0d register settings, checked %0d words", sb.events_seen,
                 PHASES, sb.words_checked);
        $display("Completed %0d pending presses, %0d mismatches", sb.presses_done, sb.errors);
        if (!failed) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== touch_coordinate_calibrator.f =====
design/tcc_pkg.sv
design/tcc_cfg_regs.sv
design/tcc_div.sv
design/touch_coordinate_calibrator.sv
verif/touch_coordinate_calibrator_test.sv
